// File: rtl/core/conv3x3_zero_pad_stream_assert.svh
// assertion macros for the 3x3 convolution stream checker
// expects clk and rst_n in the scope of each use
`ifndef CONV3X3_ZERO_PAD_STREAM_ASSERT_SVH
`define CONV3X3_ZERO_PAD_STREAM_ASSERT_SVH

// same-cycle implication, off while in reset
`define C3ZP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define C3ZP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// what must hold in the cycle after reset is applied
`define C3ZP_ASSERT_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) (!rst_n) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/c3zp_pkg.sv
`timescale 1ns / 1ps
// shared constants, kernel table and types of the 3x3 convolution stream
// no dependencies
package c3zp_pkg;

  localparam int MAX_SIDE    = 32;
  localparam int SAMPLE_BITS = 16;
  localparam int RESULT_BITS = 20;
  localparam int POS_BITS    = 5;

  localparam int CFG_BITS    = 6;
  localparam int CFG_RESET   = 32;
  localparam int PDATA_BITS  = 32;
  localparam int PADDR_BITS  = 3;
  localparam int REG_MATRIX_SIZE = 0;

  localparam int COL_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int ROW_W  = $clog2(MAX_SIDE + 2);
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int CMP_W  = ROW_W + 2;
  localparam int LINE_W = 2 * SAMPLE_BITS;
  localparam int SUM_W  = SAMPLE_BITS + 4;
  localparam int SIDE_RESET = (CFG_RESET > MAX_SIDE) ? MAX_SIDE : CFG_RESET;

  // kernel as written, flipped when applied to the window
  localparam logic signed [1:0] KERNEL [3][3] = '{
    '{ 2'sd1,  2'sd1, -2'sd1},
    '{-2'sd1,  2'sd1, -2'sd1},
    '{ 2'sd1,  2'sd1,  2'sd1}
  };

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic             valid;
    sample_t          sample;
    logic [COL_W-1:0] col;
    logic             emit;
    logic             eor;
  } item_t;

  typedef struct packed {
    logic             emit;
    logic             eor;
    logic             eof;
    logic [COL_W-1:0] row;
    logic [COL_W-1:0] col;
  } p2_t;

  typedef struct packed {
    logic signed [RESULT_BITS-1:0] result_value;
    logic [POS_BITS-1:0]           row_index;
    logic [POS_BITS-1:0]           column_index;
    logic                          end_of_run;
    logic                          end_of_frame;
  } res_t;

endpackage

// File: rtl/core/c3zp_in_if.sv
`timescale 1ns / 1ps
// sample channel: valid/ready handshake with one signed sample per request
// depends on c3zp_pkg
interface c3zp_in_if;
  import c3zp_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// File: rtl/core/c3zp_out_if.sv
`timescale 1ns / 1ps
// result channel: valid/ready handshake with one convolution result per request
// depends on c3zp_pkg
interface c3zp_out_if;
  import c3zp_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [RESULT_BITS-1:0] result_value;
  logic [POS_BITS-1:0]           row_index;
  logic [POS_BITS-1:0]           column_index;
  logic                          end_of_run;
  logic                          end_of_frame;

  modport source (output valid, output result_value, output row_index,
                  output column_index, output end_of_run, output end_of_frame,
                  input ready);
  modport sink (input valid, input result_value, input row_index,
                input column_index, input end_of_run, input end_of_frame,
                output ready);
endinterface

// File: rtl/core/c3zp_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// a read of the address being written returns the new data
module c3zp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= (we && (waddr == raddr)) ? wdata : mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// File: rtl/core/c3zp_seq.sv
`timescale 1ns / 1ps
// input position tracking, end-of-frame flush and the line read stage
// depends on c3zp_pkg
module c3zp_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_clear,
  input  logic [c3zp_pkg::SIDE_W-1:0]  side,
  input  logic                         in_valid,
  input  c3zp_pkg::sample_t            in_sample,
  output logic                         in_ready,
  input  logic                         p2_take,
  output logic                         rd_en,
  output logic [c3zp_pkg::COL_W-1:0]   rd_addr,
  output c3zp_pkg::item_t              p1
);
  import c3zp_pkg::*;

  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic             flush_r, flush_nxt;
  item_t            p1_r, p1_nxt;
  logic [CMP_W-1:0] side_c;
  logic             p1_take, issue, col_wrap, row_final, last_real, flush_end, emit;

  always_comb begin
    side_c    = CMP_W'(side);
    p1_take   = !p1_r.valid || p2_take;
    col_wrap  = (CMP_W'(col_r) + CMP_W'(1)) == side_c;
    row_final = (CMP_W'(row_r) + CMP_W'(1)) == side_c;
    last_real = !flush_r && row_final && col_wrap;
    flush_end = flush_r && (CMP_W'(row_r) == (side_c + CMP_W'(1)));
    // results start one row plus one sample behind the input
    emit      = !((row_r == '0) || ((row_r == ROW_W'(1)) && (col_r == '0)));
    in_ready  = !flush_r && p1_take;
    issue     = (in_valid && in_ready) || (flush_r && p1_take);

    row_nxt   = row_r;
    col_nxt   = col_r;
    flush_nxt = flush_r;
    if (cfg_clear) begin
      row_nxt   = '0;
      col_nxt   = '0;
      flush_nxt = 1'b0;
    end else if (issue) begin
      if (flush_end) begin
        row_nxt   = '0;
        col_nxt   = '0;
        flush_nxt = 1'b0;
      end else if (col_wrap) begin
        col_nxt   = '0;
        row_nxt   = row_r + ROW_W'(1);
        flush_nxt = flush_r || last_real;
      end else begin
        col_nxt   = col_r + COL_W'(1);
      end
    end

    p1_nxt = p1_r;
    if (issue) begin
      // flush items behave as zero samples below the frame
      p1_nxt.valid  = 1'b1;
      p1_nxt.sample = flush_r ? '0 : in_sample;
      p1_nxt.col    = col_r;
      p1_nxt.emit   = emit;
      p1_nxt.eor    = !flush_r && !last_real;
    end else if (p2_take) begin
      p1_nxt.valid  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r   <= '0;
      col_r   <= '0;
      flush_r <= 1'b0;
      p1_r    <= '0;
    end else begin
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      flush_r <= flush_nxt;
      p1_r    <= p1_nxt;
    end
  end

  assign rd_en   = issue;
  assign rd_addr = col_r;
  assign p1      = p1_r;
endmodule

// File: rtl/core/c3zp_win.sv
`timescale 1ns / 1ps
// 3x3 window, output position tracking, edge masking, kernel sum, result register
// depends on c3zp_pkg and c3zp_out_if
module c3zp_win (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_clear,
  input  logic [c3zp_pkg::SIDE_W-1:0]  side,
  input  c3zp_pkg::item_t              p1,
  input  logic [c3zp_pkg::LINE_W-1:0]  line_rdata,
  output logic                         p2_take,
  output logic                         wr_en,
  output logic [c3zp_pkg::COL_W-1:0]   wr_addr,
  output logic [c3zp_pkg::LINE_W-1:0]  wr_data,
  c3zp_out_if.source                   out_chan
);
  import c3zp_pkg::*;

  sample_t          win_r [3][3];
  sample_t          win_nxt [3][3];
  logic             p2_valid_r, p2_valid_nxt;
  p2_t              p2_r, p2_nxt;
  logic [COL_W-1:0] orow_r, orow_nxt, ocol_r, ocol_nxt;
  logic             out_valid_r, out_valid_nxt;
  res_t             out_r, out_nxt;

  logic                    p1_go, p2_go, out_free, ocol_wrap, orow_final, eof_now;
  logic [CMP_W-1:0]        side_c;
  logic                    keep_row [3];
  logic                    keep_col [3];
  logic signed [SUM_W-1:0] row_sum [3];
  logic signed [SUM_W-1:0] total;

  // handshake between stages
  always_comb begin
    out_free = !out_valid_r || out_chan.ready;
    p2_go    = p2_valid_r && (!p2_r.emit || out_free);
    p2_take  = !p2_valid_r || p2_go;
    p1_go    = p1.valid && p2_take;
  end

  // line store holds rows r-1 (upper half) and r-2 (lower half) per column
  assign wr_en   = p1_go;
  assign wr_addr = p1.col;
  assign wr_data = {p1.sample, line_rdata[LINE_W-1:SAMPLE_BITS]};

  always_comb begin
    win_nxt = win_r;
    if (p1_go) begin
      for (int i = 0; i < 3; i++) begin
        win_nxt[i][0] = win_r[i][1];
        win_nxt[i][1] = win_r[i][2];
      end
      win_nxt[0][2] = line_rdata[SAMPLE_BITS-1:0];
      win_nxt[1][2] = line_rdata[LINE_W-1:SAMPLE_BITS];
      win_nxt[2][2] = p1.sample;
    end
  end

  // output position
  always_comb begin
    side_c     = CMP_W'(side);
    ocol_wrap  = (CMP_W'(ocol_r) + CMP_W'(1)) == side_c;
    orow_final = (CMP_W'(orow_r) + CMP_W'(1)) == side_c;
    eof_now    = ocol_wrap && orow_final;

    orow_nxt = orow_r;
    ocol_nxt = ocol_r;
    if (cfg_clear) begin
      orow_nxt = '0;
      ocol_nxt = '0;
    end else if (p1_go && p1.emit) begin
      if (eof_now) begin
        orow_nxt = '0;
        ocol_nxt = '0;
      end else if (ocol_wrap) begin
        ocol_nxt = '0;
        orow_nxt = orow_r + COL_W'(1);
      end else begin
        ocol_nxt = ocol_r + COL_W'(1);
      end
    end

    p2_nxt       = p2_r;
    p2_valid_nxt = p2_valid_r;
    if (p1_go) begin
      p2_valid_nxt = 1'b1;
      p2_nxt.emit  = p1.emit;
      p2_nxt.eor   = p1.eor;
      p2_nxt.eof   = eof_now;
      p2_nxt.row   = orow_r;
      p2_nxt.col   = ocol_r;
    end else if (p2_go) begin
      p2_valid_nxt = 1'b0;
    end
  end

  // masked, flipped-kernel sum
  always_comb begin
    keep_row[0] = p2_r.row != '0;
    keep_row[1] = 1'b1;
    keep_row[2] = (CMP_W'(p2_r.row) + CMP_W'(1)) != side_c;
    keep_col[0] = p2_r.col != '0;
    keep_col[1] = 1'b1;
    keep_col[2] = (CMP_W'(p2_r.col) + CMP_W'(1)) != side_c;
    for (int i = 0; i < 3; i++) begin
      row_sum[i] = '0;
      for (int j = 0; j < 3; j++) begin
        if (keep_row[i] && keep_col[j]) begin
          if (KERNEL[2-i][2-j] < 2'sd0) begin
            row_sum[i] = row_sum[i] - SUM_W'(win_r[i][j]);
          end else begin
            row_sum[i] = row_sum[i] + SUM_W'(win_r[i][j]);
          end
        end
      end
    end
    total = row_sum[0] + row_sum[1] + row_sum[2];
  end

  // result register
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (p2_go && p2_r.emit) begin
      out_valid_nxt        = 1'b1;
      out_nxt.result_value = RESULT_BITS'(total);
      out_nxt.row_index    = POS_BITS'(p2_r.row);
      out_nxt.column_index = POS_BITS'(p2_r.col);
      out_nxt.end_of_run   = p2_r.eor || p2_r.eof;
      out_nxt.end_of_frame = p2_r.eof;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
      p2_valid_r  <= 1'b0;
      orow_r      <= '0;
      ocol_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      win_r       <= win_nxt;
      p2_valid_r  <= p2_valid_nxt;
      orow_r      <= orow_nxt;
      ocol_r      <= ocol_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p2_r  <= p2_nxt;
    out_r <= out_nxt;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.result_value = out_r.result_value;
  assign out_chan.row_index    = out_r.row_index;
  assign out_chan.column_index = out_r.column_index;
  assign out_chan.end_of_run   = out_r.end_of_run;
  assign out_chan.end_of_frame = out_r.end_of_frame;
endmodule

// File: rtl/core/conv3x3_zero_pad_stream.sv
`timescale 1ns / 1ps
// top level of the zero-padded 3x3 convolution stream with its register port
// depends on c3zp_pkg, c3zp_in_if, c3zp_out_if, c3zp_ram, c3zp_seq, c3zp_win
//
//   port       dir   contents
//   in_chan    in    sample, raster order, valid/ready
//   out_chan   out   result_value, row_index, column_index, end_of_run, end_of_frame
//   psel..     in    apb-style register port, matrix_size at byte address 0
//
// one sample per cycle unless stalled or flushing; results pass the p1, p2 and result registers
// the last sample of a frame is followed by side+1 flush items with in ready low,
// each pushing a zero sample through the window and releasing one result
// (at side 1 only the second flush item releases one)
// out ready low stalls the window stage and then the input
// synchronous reset; line store contents are not cleared
module conv3x3_zero_pad_stream (
  input  logic                             clk,
  input  logic                             rst_n,
  c3zp_in_if.sink                          in_chan,
  c3zp_out_if.source                       out_chan,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [c3zp_pkg::PADDR_BITS-1:0]  paddr,
  input  logic [c3zp_pkg::PDATA_BITS-1:0]  pwdata,
  output logic [c3zp_pkg::PDATA_BITS-1:0]  prdata,
  output logic                             pready
);
  import c3zp_pkg::*;

  logic [CFG_BITS-1:0] size_r, size_nxt;
  logic [SIDE_W-1:0]   side_r, side_nxt;
  logic [CFG_BITS-1:0] wr_val;
  logic                cfg_wr, reg_hit;

  logic              rd_en, wr_en, p2_take;
  logic [COL_W-1:0]  rd_addr, wr_addr;
  logic [LINE_W-1:0] wr_data, line_rdata;
  item_t             p1;

  always_comb begin
    reg_hit  = paddr[PADDR_BITS-1:2] == (PADDR_BITS-2)'(REG_MATRIX_SIZE);
    cfg_wr   = psel && penable && pwrite && reg_hit;
    wr_val   = pwdata[CFG_BITS-1:0];
    size_nxt = size_r;
    side_nxt = side_r;
    if (cfg_wr) begin
      size_nxt = wr_val;
      if (wr_val == '0) begin
        side_nxt = SIDE_W'(1);
      end else if (wr_val > CFG_BITS'(MAX_SIDE)) begin
        side_nxt = SIDE_W'(MAX_SIDE);
      end else begin
        side_nxt = SIDE_W'(wr_val);
      end
    end
    prdata = reg_hit ? PDATA_BITS'(size_r) : '0;
  end

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= CFG_BITS'(CFG_RESET);
      side_r <= SIDE_W'(SIDE_RESET);
    end else begin
      size_r <= size_nxt;
      side_r <= side_nxt;
    end
  end

  c3zp_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_clear (cfg_wr),
    .side      (side_r),
    .in_valid  (in_chan.valid),
    .in_sample (in_chan.sample),
    .in_ready  (in_chan.ready),
    .p2_take   (p2_take),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .p1        (p1)
  );

  c3zp_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_SIDE)
  ) u_line (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (line_rdata)
  );

  c3zp_win u_win (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_clear  (cfg_wr),
    .side       (side_r),
    .p1         (p1),
    .line_rdata (line_rdata),
    .p2_take    (p2_take),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .out_chan   (out_chan)
  );
endmodule

// File: rtl/core/c3zp_checker.sv
`timescale 1ns / 1ps
// port-level checks of the 3x3 convolution stream, bound to the top level
// depends on c3zp_pkg and conv3x3_zero_pad_stream_assert.svh
`include "conv3x3_zero_pad_stream_assert.svh"

module c3zp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [c3zp_pkg::POS_BITS-1:0] row_index,
  input logic [c3zp_pkg::POS_BITS-1:0] column_index,
  input logic                          end_of_run,
  input logic                          end_of_frame
);
  import c3zp_pkg::*;

  `C3ZP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `C3ZP_ASSERT_NOW(a_eof_run, out_valid && end_of_frame, end_of_run, "frame end without run end")
  `C3ZP_ASSERT_NOW(a_eof_corner, out_valid && end_of_frame, row_index == column_index, "frame end off the corner")
  `C3ZP_ASSERT_RESET(a_rst_idle, !out_valid, "result valid after reset")
endmodule

bind conv3x3_zero_pad_stream c3zp_checker u_c3zp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .row_index    (out_chan.row_index),
  .column_index (out_chan.column_index),
  .end_of_run   (out_chan.end_of_run),
  .end_of_frame (out_chan.end_of_frame)
);
